/* src/hets_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hets_pkg: shared types and constants
// Sizes, register indexes, opcodes and the structs that pass between the
// front queue, the search engine and the top level.
// ----------------------------------------------------------------------------
package hets_pkg;

  localparam int DEPTH       = 1024;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int SAMPLE_BITS = 16;
  localparam int POS_BITS    = 10;
  localparam int BOUND_BITS  = 17;   // level +/- hysteresis, signed
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_MODE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HYSTERESIS = 2'd3;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] EDGE_RISE   = 2'd0;
  localparam logic [1:0] EDGE_FALL   = 2'd1;
  localparam logic [1:0] EDGE_EITHER = 2'd2;

  typedef struct packed {
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic               enable;
    logic [1:0]         edge_mode;
    logic signed [15:0] level;
    logic [14:0]        hysteresis;
  } cfg_t;

  typedef struct packed {
    logic                          we;
    logic [ADDR_BITS-1:0]          waddr;
    logic signed [SAMPLE_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0]          raddr;
  } ram_req_t;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] position;
    logic                locked;
  } res_t;

endpackage
`default_nettype wire

/* src/hets_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hets_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hets_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/hets_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hets_front: input acceptance and command queue
// Takes items from the input channel, tags them push or search and holds
// them in a short queue until the search engine pops them.
// ----------------------------------------------------------------------------
module hets_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             opcode,
  input  wire logic signed [hets_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                  q_valid,
  output hets_pkg::cmd_t                        q_cmd,
  input  wire logic                             q_pop
);
  import hets_pkg::*;

  cmd_t                 slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 pop;
  cmd_t                 cmd_in;

  assign in_ready = (count != (QPTR_BITS+1)'(QDEPTH));
  assign q_valid  = (count != '0);
  assign q_cmd    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    cmd_in.op     = (opcode == OP_SEARCH) ? OP_SEARCH : OP_PUSH;
    cmd_in.sample = sample;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/hets_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hets_back: ring writer and trigger search engine
// Executes queued commands one at a time: pushes write the ring; enabled
// searches keep an in-band held lock, else stream the ring oldest to newest.
// ----------------------------------------------------------------------------
module hets_back (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    q_valid,
  input  wire hets_pkg::cmd_t                          q_cmd,
  output logic                                         q_pop,
  input  wire hets_pkg::cfg_t                          cfg,
  output hets_pkg::ram_req_t                           ram_req,
  input  wire logic signed [hets_pkg::SAMPLE_BITS-1:0] ram_rdata,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output hets_pkg::res_t                               res
);
  import hets_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_HOLD_RD  = 3'd1;
  localparam logic [2:0] S_HOLD_CHK = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_EMIT     = 3'd4;
  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

  logic [2:0]                   state;
  logic [ADDR_BITS-1:0]         wp;
  logic                         wrapped;
  logic                         locked;
  logic [ADDR_BITS-1:0]         held;
  logic [ADDR_BITS-1:0]         cnt;
  logic [ADDR_BITS-1:0]         rd_idx;
  logic                         rd_vld;
  logic                         rd_ok;
  logic signed [BOUND_BITS-1:0] lo;
  logic signed [BOUND_BITS-1:0] hi;
  logic signed [BOUND_BITS-1:0] prev;
  logic signed [BOUND_BITS-1:0] cur;
  res_t                         pend;
  logic                         rise;
  logic                         fall;
  logic                         hit;
  logic                         in_band;

  // Pop only between commands; a push completes in the pop cycle.
  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    ram_req.we    = q_pop && (q_cmd.op == OP_PUSH);
    ram_req.waddr = wp;
    ram_req.wdata = q_cmd.sample;
    ram_req.raddr = (state == S_SCAN) ? (wp + cnt) : held;
  end

  // Entries never written read as zero (ring is filled in pointer order).
  assign cur = rd_ok ? BOUND_BITS'(ram_rdata) : '0;

  always_comb begin
    rise    = (prev < lo) && (cur >= hi);
    fall    = (prev > hi) && (cur <= lo);
    in_band = (cur >= lo) && (cur <= hi);
    case (cfg.edge_mode)
      EDGE_RISE: hit = rise;
      EDGE_FALL: hit = fall;
      default:   hit = rise || fall;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_ok <= wrapped || (ram_req.raddr < wp);
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      wrapped   <= 1'b0;
      locked    <= 1'b0;
      held      <= '0;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise valid as the result leaves the emit state, drop it once taken.
      if ((state == S_EMIT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cnt    <= '0;
          rd_vld <= 1'b0;
          lo     <= BOUND_BITS'(cfg.level) - BOUND_BITS'(cfg.hysteresis);
          hi     <= BOUND_BITS'(cfg.level) + BOUND_BITS'(cfg.hysteresis);
          if (q_pop) begin
            if (q_cmd.op == OP_PUSH) begin
              wp <= wp + 1'b1;
              if (wp == LAST_ADDR) wrapped <= 1'b1;
            end else if (!cfg.enable) begin
              locked <= 1'b0;
              held   <= '0;
              pend   <= '0;
              state  <= S_EMIT;
            end else if (locked) begin
              state <= S_HOLD_RD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_HOLD_RD: begin
          state <= S_HOLD_CHK;
        end
        S_HOLD_CHK: begin
          if (in_band) begin
            pend.found    <= 1'b1;
            pend.position <= POS_BITS'(held);
            pend.locked   <= 1'b1;
            state         <= S_EMIT;
          end else begin
            locked <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt    <= cnt + 1'b1;
          rd_idx <= cnt;
          rd_vld <= 1'b1;
          prev   <= cur;
          if (rd_vld) begin
            if ((rd_idx != '0) && hit) begin
              locked        <= 1'b1;
              held          <= wp + rd_idx;
              pend.found    <= 1'b1;
              pend.position <= POS_BITS'(wp + rd_idx);
              pend.locked   <= 1'b1;
              state         <= S_EMIT;
            end else if (rd_idx == LAST_ADDR) begin
              held  <= '0;
              pend  <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: loaded only as the engine leaves the emit state.
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!out_valid || out_ready)) begin
      res <= pend;
    end
  end

endmodule
`default_nettype wire

/* src/hysteresis_edge_trigger_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hysteresis_edge_trigger_search: edge trigger with hysteresis on a ring
// Push items store samples in a 1024-entry ring; search items find or hold
// a trigger position and return one result each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, opcode, sample): opcode 0 pushes a
//   sample at the write pointer, opcode 1 runs a trigger search. Items go
//   into a four-entry queue, so the source can send up to four more items
//   while a search runs.
//   Output channel (out_valid/out_ready, found, trigger_position,
//   locked_flag): one item per search, none per push.
//   Configuration: cfg_write writes cfg_data into register cfg_index
//   (0 enable, 1 edge mode, 2 trigger level, 3 hysteresis) at the clock edge.
//   Engine steps: a push is done in the idle state. A disabled search goes
//   straight to emit; a held lock passes the hold read and check states; a
//   scan, after those when a held lock is lost first, streams the ring to the
//   first crossing or its end via the single read port, one sample a cycle.
//   Reset clears the pointer, lock, queue and output; the ring needs no
//   clearing pass, since entries not yet written read as zero by the fill
//   mark. When the receiver stalls the result waits in the output register
//   while the engine keeps draining pushes until the next result is ready.
// ----------------------------------------------------------------------------
module hysteresis_edge_trigger_search (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic                                    opcode,
  input  wire logic signed [hets_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic                                         found,
  output logic [hets_pkg::POS_BITS-1:0]                trigger_position,
  output logic                                         locked_flag,
  input  wire logic                                    cfg_write,
  input  wire logic [hets_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [hets_pkg::CFG_BITS-1:0]           cfg_data
);
  import hets_pkg::*;

  cfg_t                          cfg;
  cmd_t                          q_cmd;
  logic                          q_valid;
  logic                          q_pop;
  ram_req_t                      ram_req;
  logic signed [SAMPLE_BITS-1:0] ram_rdata;
  res_t                          res;

  // Configuration registers; hold between writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable     <= 1'b0;
      cfg.edge_mode  <= EDGE_EITHER;
      cfg.level      <= '0;
      cfg.hysteresis <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE:     cfg.enable     <= cfg_data[0];
        REG_EDGE_MODE:  cfg.edge_mode  <= cfg_data[1:0];
        REG_LEVEL:      cfg.level      <= cfg_data;
        REG_HYSTERESIS: cfg.hysteresis <= cfg_data[14:0];
        default:        cfg.enable     <= cfg.enable;
      endcase
    end
  end

  // Front: accept and queue items.
  hets_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .sample   (sample),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // Sample ring.
  hets_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Back: execute pushes and searches, drive the result register.
  hets_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign found            = res.found;
  assign trigger_position = res.position;
  assign locked_flag      = res.locked;

endmodule
`default_nettype wire

/* verif/hets_trigger_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hets_trigger_checker: result checker for the hysteresis edge trigger
// Watches the item channels and the register port, keeps its own ring,
// pointer, lock and settings, predicts the result of every search and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module hets_trigger_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic                                    opcode,
  input  logic signed [hets_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic                                    found,
  input  logic [hets_pkg::POS_BITS-1:0]           trigger_position,
  input  logic                                    locked_flag,
  input  logic                                    cfg_write,
  input  logic [hets_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [hets_pkg::CFG_BITS-1:0]           cfg_data,
  output int                                      fail_count,
  output int                                      pending,
  output int                                      push_count,
  output int                                      search_count,
  output int                                      found_count,
  output int                                      hold_count
);
  import hets_pkg::*;

  localparam int REPORT_LIMIT = 20;

  logic signed [SAMPLE_BITS-1:0] ring [DEPTH];
  logic [ADDR_BITS-1:0]          wr_ptr;
  logic                          lock_q;
  logic [ADDR_BITS-1:0]          held_pos;
  cfg_t                          cfg;
  res_t                          expected_triggers [$];
  int fails    = 0;
  int pushes   = 0;
  int searches = 0;
  int hits     = 0;
  int holds    = 0;

  task automatic report_field(input string field, input logic [POS_BITS-1:0] want_v,
                              input logic [POS_BITS-1:0] got_v);
    fails++;
    if (fails <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  // When enabled, hold the lock if the held sample is still in the band, else scan
  // the ring from oldest to newest for the first crossing of the chosen kind.
  task automatic predict_search(output res_t r);
    int lvl, lo, hi, older, newer, held_val;
    logic [ADDR_BITS-1:0] a, b;
    logic rise, fall, hit;
    r = '0;
    if (!cfg.enable) begin
      lock_q   = 1'b0;
      held_pos = '0;
      return;
    end
    lvl = $signed(cfg.level);
    lo  = lvl - int'(cfg.hysteresis);
    hi  = lvl + int'(cfg.hysteresis);
    if (lock_q) begin
      held_val = ring[held_pos];
      if (held_val >= lo && held_val <= hi) begin
        r.found    = 1'b1;
        r.position = held_pos;
        r.locked   = 1'b1;
        holds++;
        return;
      end
      lock_q = 1'b0;
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      a     = wr_ptr + ADDR_BITS'(i);
      b     = a + 1'b1;
      older = ring[a];
      newer = ring[b];
      rise  = (older < lo) && (newer >= hi);
      fall  = (older > hi) && (newer <= lo);
      case (cfg.edge_mode)
        EDGE_RISE: hit = rise;
        EDGE_FALL: hit = fall;
        default:   hit = rise | fall;
      endcase
      if (hit) begin
        lock_q     = 1'b1;
        held_pos   = b;
        r.found    = 1'b1;
        r.position = b;
        r.locked   = 1'b1;
        return;
      end
    end
    held_pos = '0;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      foreach (ring[k]) ring[k] = '0;
      wr_ptr         = '0;
      lock_q         = 1'b0;
      held_pos       = '0;
      cfg.enable     = 1'b0;
      cfg.edge_mode  = EDGE_EITHER;
      cfg.level      = '0;
      cfg.hysteresis = '0;
      expected_triggers.delete();
    end else begin
      // results first: nothing accepted at this edge can have produced one yet
      if (out_valid && out_ready) begin
        if (expected_triggers.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: unexpected result found=%0b position=%0d locked=%0b, %s",
                     $time, found, trigger_position, locked_flag, "expected none");
        end else begin
          want = expected_triggers.pop_front();
          if (found !== want.found)
            report_field("found", POS_BITS'(want.found), POS_BITS'(found));
          if (trigger_position !== want.position)
            report_field("trigger_position", want.position, trigger_position);
          if (locked_flag !== want.locked)
            report_field("locked_flag", POS_BITS'(want.locked), POS_BITS'(locked_flag));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ENABLE:     cfg.enable     = cfg_data[0];
          REG_EDGE_MODE:  cfg.edge_mode  = cfg_data[1:0];
          REG_LEVEL:      cfg.level      = cfg_data[15:0];
          REG_HYSTERESIS: cfg.hysteresis = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (opcode == OP_PUSH) begin
          ring[wr_ptr] = sample;
          wr_ptr       = wr_ptr + 1'b1;
          pushes++;
        end else begin
          predict_search(want);
          expected_triggers.push_back(want);
          searches++;
          if (want.found) hits++;
        end
      end
    end
    fail_count   <= fails;
    pending      <= expected_triggers.size();
    push_count   <= pushes;
    search_count <= searches;
    found_count  <= hits;
    hold_count   <= holds;
  end

endmodule

/* verif/tb_hysteresis_edge_trigger_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hysteresis_edge_trigger_search: testbench for the edge trigger block
// Drives push and search items and register writes into the block, with a
// directed opening and then random phases under several settings and flow
// patterns. A separate checker predicts and compares every result; this
// module makes the stimulus, runs a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb_hysteresis_edge_trigger_search;
  import hets_pkg::*;

  localparam int RESET_CYCLES   = 7;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 153;
  localparam int SEARCH_PCT     = 8;
  localparam int SETTLE_CYCLES  = 16;    // queued pushes still draining
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 20000; // far longer than a full scan
  localparam int DIRECTED_SETTINGS = 5;

  // edge mode value with no name of its own; the block treats it as either edge
  localparam logic [1:0] EDGE_SPARE = 2'd3;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic                          opcode    = OP_PUSH;
  logic signed [SAMPLE_BITS-1:0] sample    = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          found;
  logic [POS_BITS-1:0]           trigger_position;
  logic                          locked_flag;
  logic                          cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index = REG_ENABLE;
  logic [CFG_BITS-1:0]           cfg_data  = '0;

  int fail_count, pending, push_count, search_count, found_count, hold_count;

  int gap_pct     = 0;   // chance per cycle that the sender holds off
  int stall_pct   = 0;   // chance per cycle that the receiver stalls
  int idle_cycles = 0;

  // band of the current setting, used to aim samples at the crossing edges
  int band_lo  = 0;
  int band_hi  = 0;
  int band_mid = 0;

  // per-phase settings; the extremes of level and hysteresis are among them
  int phase_level [PHASES] = '{0, 80, -200, 32767, 16, -32768, 0, 512, -1000, 7, -7, 3000};
  int phase_hyst  [PHASES] = '{0, 16, 32767, 0, 3, 32767, 100, 0, 40, 1, 20000, 2000};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hysteresis_edge_trigger_search i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .trigger_position (trigger_position),
    .locked_flag      (locked_flag),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  hets_trigger_checker i_trigger_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .trigger_position (trigger_position),
    .locked_flag      (locked_flag),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .push_count       (push_count),
    .search_count     (search_count),
    .found_count      (found_count),
    .hold_count       (hold_count)
  );

  // Receiver: stall at random with the chance of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("hysteresis_edge_trigger_search verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one item: idle first if the phase asks, then hold valid and the
  // payload until the block takes it. Returns at the accepting edge.
  task automatic send_item(input logic op, input logic signed [SAMPLE_BITS-1:0] value);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    sample   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back, then
  // give trailing pushes in the block's queue time to drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; unused data bits carry noise.
  task automatic apply_settings(input logic en, input logic [1:0] mode,
                                input int level, input int hyst);
    cfg_write <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_data  <= {15'($urandom()), en};
    @(posedge clk);
    cfg_index <= REG_EDGE_MODE;
    cfg_data  <= {14'($urandom()), mode};
    @(posedge clk);
    cfg_index <= REG_LEVEL;
    cfg_data  <= 16'(level);
    @(posedge clk);
    cfg_index <= REG_HYSTERESIS;
    cfg_data  <= {1'($urandom()), 15'(hyst)};
    @(posedge clk);
    cfg_write <= 1'b0;
    band_mid = level;
    band_lo  = level - hyst;
    band_hi  = level + hyst;
  endtask

  // Aim half the samples at the band edges and the level so crossings and held locks are
  // common; mix in the rails and fully random values.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0:       v = band_lo - 1;
      1:       v = band_lo;
      2:       v = band_hi;
      3:       v = band_hi + 1;
      4:       v = band_mid;
      5:       v = -32768;
      6:       v = 32767;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[SAMPLE_BITS-1:0];
  endfunction

  initial begin
    logic op;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // --- directed opening ---
    // search while disabled (the reset state)
    send_item(OP_SEARCH, 16'sd0);
    wait_drained();

    // enable, level 0, no hysteresis: an empty ring gives no crossing
    apply_settings(1'b1, EDGE_EITHER, 0, 0);
    send_item(OP_SEARCH, -16'sd1);
    // rise from -1 to 0 lands exactly on the level, so the lock holds next time
    send_item(OP_PUSH, -16'sd1);
    send_item(OP_PUSH, 16'sd0);
    send_item(OP_SEARCH, 16'sd0);
    send_item(OP_SEARCH, 16'sd0);
    // rail to rail falling pair after it; the held lock still wins
    send_item(OP_PUSH, 16'sh7fff);
    send_item(OP_PUSH, -16'sh8000);
    send_item(OP_SEARCH, 16'sd0);
    wait_drained();

    // move the band off the held sample: unlock and find the falling pair
    apply_settings(1'b1, EDGE_FALL, 100, 50);
    send_item(OP_SEARCH, 16'sd0);
    wait_drained();

    // widest band with the spare edge mode: nothing can cross
    apply_settings(1'b1, EDGE_SPARE, 32767, 32767);
    send_item(OP_SEARCH, 16'sd0);
    wait_drained();

    // lowest level, no hysteresis, rising: nothing lies below the level
    apply_settings(1'b1, EDGE_RISE, -32768, 0);
    send_item(OP_SEARCH, 16'sd0);
    wait_drained();

    // disable again: search clears the lock
    apply_settings(1'b0, EDGE_EITHER, 0, 0);
    send_item(OP_SEARCH, 16'sd0);
    wait_drained();

    // --- random phases ---
    for (int p = 0; p < PHASES; p++) begin
      apply_settings(p != 9, 2'((p / 2) % 4), phase_level[p], phase_hyst[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 80; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 80; end
        default: begin gap_pct = 27; stall_pct <= 27; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < SEARCH_PCT) ? OP_SEARCH : OP_PUSH;
        send_item(op, pick_sample());
        // hold off the sender once until the block has answered everything
        if (p == 1 && n == PHASE_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end

    gap_pct = 0;
    stall_pct <= 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pushes and %0d searches over %0d register settings and four flow patterns.",
             push_count, search_count, PHASES + DIRECTED_SETTINGS);
    $display("%0d searches triggered, %0d of them on a held lock; %0d came back empty.",
             found_count, hold_count, search_count - found_count);
    if (fail_count == 0 && pending == 0) begin
      $display("hysteresis_edge_trigger_search verification clean");
    end else begin
      $display("hysteresis_edge_trigger_search verification failed");
    end
    $finish;
  end

endmodule
